>>> hdl/afs_pkg.sv
`default_nettype none

package afs_pkg;

   localparam int FRAME_DEPTH = 64;
   localparam int FRAME_W     = $clog2(FRAME_DEPTH);
   localparam int BOUND_W     = ((FRAME_W > 7) ? FRAME_W : 7) + 1;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   localparam logic [1:0] CSR_LOOP_MODE   = 2'd0;
   localparam logic [1:0] CSR_FIRST_FRAME = 2'd1;
   localparam logic [1:0] CSR_FRAME_COUNT = 2'd2;

   localparam logic [1:0] MODE_FORWARD       = 2'd0;
   localparam logic [1:0] MODE_REVERSE       = 2'd1;
   localparam logic [1:0] MODE_PING_PONG     = 2'd2;
   localparam logic [1:0] MODE_PING_PONG_REV = 2'd3;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef logic [FRAME_W-1:0] frame_type;

   typedef struct packed {
      logic [1:0] mode;
      frame_type  lo;
      frame_type  hi;
   } loop_cfg_type;

endpackage

`default_nettype wire

>>> hdl/animation_frame_sequencer_core.sv
// Sprite animation frame sequencer.
// Request beats arrive on req_tvalid/req_tready. req_tuser selects the
// command: low is a time tick that adds elapsed_ms to the frame timer, high
// writes entry_duration into the duration table at entry_index. Every request
// beat produces exactly one response beat on rsp_tvalid/rsp_tready carrying
// the current frame, an advanced flag and the ping-pong direction.
// Loop mode, first frame and frame count are written on the csr channel,
// which is always ready; write them only while no request is in flight.
// A request beat is registered in the input register at acceptance and is
// processed once the response register is free; its response is registered
// there and held on rsp_tvalid until the receiver takes it.
// Throughput is one beat per cycle while rsp_tready is high, set by the add,
// duration compare and loop-mode selection feeding the registered table read.
// When the receiver stalls, the response is held and one more request can be
// accepted into the input register before req_tready drops.
// Reset clears the timer, frame index, direction and all three csr registers
// to forward mode, first frame zero and a one-frame loop. The duration table
// is not cleared; a frame must have its duration written before it is timed.
`default_nettype none

module animation_frame_sequencer_core
   import afs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // elapsed_ms[15:0], entry_index[21:16], entry_duration[37:22], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // current_frame[5:0], advanced[6], going_down[7]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [6:0]            csr_data
);

   loop_cfg_type loop_cfg;
   logic         tbl_wr_en;
   frame_type    tbl_wr_addr;
   logic [15:0]  tbl_wr_data;
   frame_type    tbl_rd_addr;
   logic [15:0]  tbl_rd_data;

   afs_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .loop_cfg  (loop_cfg)
   );

   afs_frame_table u_frame_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   afs_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .loop_cfg    (loop_cfg),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data)
   );

endmodule

`default_nettype wire

>>> hdl/afs_config.sv
`default_nettype none

module afs_config
   import afs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [6:0]   csr_data,
   output loop_cfg_type      loop_cfg
);

   localparam logic [BOUND_W-1:0] LAST = BOUND_W'(FRAME_DEPTH - 1);

   logic [1:0]         loop_mode_ff, loop_mode_in;
   logic [5:0]         first_frame_ff, first_frame_in;
   logic [6:0]         frame_count_ff, frame_count_in;
   logic               csr_write;
   logic [BOUND_W-1:0] lo_w;
   logic [BOUND_W-1:0] cnt_w;
   logic [BOUND_W-1:0] hi_w;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      loop_mode_in   = loop_mode_ff;
      first_frame_in = first_frame_ff;
      frame_count_in = frame_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LOOP_MODE:   loop_mode_in   = csr_data[1:0];
            CSR_FIRST_FRAME: first_frame_in = csr_data[5:0];
            CSR_FRAME_COUNT: frame_count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff   <= MODE_FORWARD;
         first_frame_ff <= '0;
         frame_count_ff <= 7'd1;
      end else begin
         loop_mode_ff   <= loop_mode_in;
         first_frame_ff <= first_frame_in;
         frame_count_ff <= frame_count_in;
      end
   end

   // The loop is clamped to the table; a zero count is taken as one frame.
   always_comb begin
      lo_w = BOUND_W'(first_frame_ff);
      if (lo_w > LAST) begin
         lo_w = LAST;
      end
      cnt_w = (frame_count_ff == '0) ? BOUND_W'(1) : BOUND_W'(frame_count_ff);
      hi_w  = lo_w + cnt_w - BOUND_W'(1);
      if (hi_w > LAST) begin
         hi_w = LAST;
      end
      loop_cfg.mode = loop_mode_ff;
      loop_cfg.lo   = lo_w[FRAME_W-1:0];
      loop_cfg.hi   = hi_w[FRAME_W-1:0];
   end

endmodule

`default_nettype wire

>>> hdl/afs_frame_table.sv
`default_nettype none

module afs_frame_table
   import afs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        wr_en,
   input  wire frame_type   wr_addr,
   input  wire logic [15:0] wr_data,
   input  wire frame_type   rd_addr,
   output logic [15:0]      rd_data
);

   logic [15:0] mem_ff [FRAME_DEPTH];
   logic [15:0] rd_data_ff;

   // A write to the entry being read is passed straight to the read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/afs_sequencer.sv
`default_nettype none

module afs_sequencer
   import afs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire loop_cfg_type          loop_cfg,
   output logic                       tbl_wr_en,
   output frame_type                  tbl_wr_addr,
   output logic [15:0]                tbl_wr_data,
   output frame_type                  tbl_rd_addr,
   input  wire logic [15:0]           tbl_rd_data
);

   logic            in_valid_ff, in_valid_in;
   logic            in_command_ff;
   logic [15:0]     in_elapsed_ff;
   logic [5:0]      in_index_ff;
   logic [15:0]     in_duration_ff;

   logic [15:0]     elapsed_timer_ff, elapsed_timer_in;
   frame_type       frame_index_ff, frame_index_in;
   logic            direction_ff, direction_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [5:0]      rsp_frame_ff;
   logic            rsp_advanced_ff;
   logic            rsp_going_down_ff;

   logic            req_take;
   logic            fire;
   logic [15:0]     timer_sum;
   frame_type       step_frame;
   logic            step_toggle;
   logic            down;
   logic            advanced_in;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff  <= req_tuser;
         in_elapsed_ff  <= req_tdata[15:0];
         in_index_ff    <= req_tdata[21:16];
         in_duration_ff <= req_tdata[37:22];
      end
   end

   // Next frame by loop mode; step_toggle flips the ping-pong direction.
   always_comb begin
      step_frame  = frame_index_ff;
      step_toggle = 1'b0;
      down        = direction_ff ^ (loop_cfg.mode == MODE_PING_PONG_REV);
      case (loop_cfg.mode)
         MODE_FORWARD: begin
            step_frame = (frame_index_ff >= loop_cfg.hi) ? loop_cfg.lo
                                                         : frame_index_ff + 1'b1;
         end
         MODE_REVERSE: begin
            step_frame = (frame_index_ff <= loop_cfg.lo) ? loop_cfg.hi
                                                         : frame_index_ff - 1'b1;
         end
         MODE_PING_PONG, MODE_PING_PONG_REV: begin
            if (down) begin
               if (frame_index_ff <= loop_cfg.lo) begin
                  step_toggle = 1'b1;
                  step_frame  = (frame_index_ff >= loop_cfg.hi) ? loop_cfg.hi
                                                                : frame_index_ff + 1'b1;
               end else begin
                  step_frame = frame_index_ff - 1'b1;
               end
            end else begin
               if (frame_index_ff >= loop_cfg.hi) begin
                  step_toggle = 1'b1;
                  step_frame  = (frame_index_ff > loop_cfg.lo) ? frame_index_ff - 1'b1
                                                               : loop_cfg.lo;
               end else begin
                  step_frame = frame_index_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign timer_sum = elapsed_timer_ff + in_elapsed_ff;

   always_comb begin
      elapsed_timer_in = elapsed_timer_ff;
      frame_index_in   = frame_index_ff;
      direction_in     = direction_ff;
      if (fire && (in_command_ff == CMD_TICK)) begin
         if (timer_sum > tbl_rd_data) begin
            elapsed_timer_in = '0;
            frame_index_in   = step_frame;
            direction_in     = direction_ff ^ step_toggle;
         end else begin
            elapsed_timer_in = timer_sum;
         end
      end
      advanced_in = (frame_index_in != frame_index_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_timer_ff <= '0;
         frame_index_ff   <= '0;
         direction_ff     <= 1'b0;
      end else begin
         elapsed_timer_ff <= elapsed_timer_in;
         frame_index_ff   <= frame_index_in;
         direction_ff     <= direction_in;
      end
   end

   // The table is read at the frame that the next item will see.
   assign tbl_rd_addr = frame_index_in;
   assign tbl_wr_en   = fire && (in_command_ff == CMD_WRITE)
                        && (32'(in_index_ff) < 32'(FRAME_DEPTH));
   assign tbl_wr_addr = FRAME_W'(in_index_ff);
   assign tbl_wr_data = in_duration_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_frame_ff      <= 6'(frame_index_in);
         rsp_advanced_ff   <= advanced_in;
         rsp_going_down_ff <= direction_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_going_down_ff, rsp_advanced_ff, rsp_frame_ff};

`ifndef ASSERT_OFF
   a_frame_in_table: assert property (@(posedge clock) disable iff (reset)
      32'(frame_index_ff) <= 32'(FRAME_DEPTH - 1))
      else $error("frame index left the duration table");

   a_write_no_advance: assert property (@(posedge clock) disable iff (reset)
      fire && (in_command_ff == CMD_WRITE) |=> !rsp_advanced_ff)
      else $error("write beat reported a frame advance");

   a_advance_clears_timer: assert property (@(posedge clock) disable iff (reset)
      fire && (in_command_ff == CMD_TICK) && advanced_in |=> elapsed_timer_ff == '0)
      else $error("timer not cleared on frame advance");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(frame_index_ff) && $stable(elapsed_timer_ff)
                && $stable(direction_ff))
      else $error("sequencer state changed without a beat");
`endif

endmodule

`default_nettype wire

>>> sim/animation_frame_sequencer_core_test.sv
`default_nettype none

module animation_frame_sequencer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import afs_pkg::*;

   localparam int PHASES      = 12;
   localparam int PHASE_BEATS = 150;
   localparam int PLAN_ROWS   = 29;
   localparam int HOLD_AT     = 400;
   localparam int LONG_HOLD   = 150;
   localparam int SETTLE      = 20;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic       going_down;
      logic       advanced;
      logic [5:0] frame;
   } frame_status_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [1:0]       csr_idx;
      logic [6:0]       csr_val;
      logic             cmd;
      logic [15:0]      ms;
      logic [5:0]       idx;
      logic [15:0]      dur;
      logic             pinned;
      frame_status_type want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [6:0]            csr_data;

   logic [1:0]  seq_mode;
   logic [5:0]  seq_first;
   logic [6:0]  seq_count;
   logic [15:0] seq_timer;
   logic [5:0]  seq_frame;
   logic        seq_down;
   logic [15:0] duration_tab [64];
   bit          duration_set [64];

   frame_status_type status_queue [$];
   plan_row_type     plan [PLAN_ROWS];

   int fault_count;
   int status_seen;
   int tick_count;
   int step_count;
   int write_count;
   int cycle_count;
   int rx_hold;
   int tx_mode;
   int rx_mode;

   animation_frame_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(input int mode);
      int r;
      if (mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [5:0] next_loop_frame(input logic [5:0] f);
      int lo;
      int hi;
      int cur;
      logic down;
      lo = seq_first;
      hi = lo + ((seq_count == 0) ? 1 : int'(seq_count)) - 1;
      if (hi > FRAME_DEPTH - 1) hi = FRAME_DEPTH - 1;
      cur = f;
      case (seq_mode)
         MODE_FORWARD: return (cur >= hi) ? 6'(lo) : 6'(cur + 1);
         MODE_REVERSE: return (cur <= lo) ? 6'(hi) : 6'(cur - 1);
         default: begin
            down = seq_down ^ (seq_mode == MODE_PING_PONG_REV);
            if (down) begin
               if (cur <= lo) begin
                  seq_down = ~seq_down;
                  return (cur + 1 > hi) ? 6'(hi) : 6'(cur + 1);
               end
               return 6'(cur - 1);
            end
            if (cur >= hi) begin
               seq_down = ~seq_down;
               return (cur > lo) ? 6'(cur - 1) : 6'(lo);
            end
            return 6'(cur + 1);
         end
      endcase
   endfunction

   function automatic frame_status_type step_sequencer(input logic cmd,
                                                       input logic [15:0] ms,
                                                       input logic [5:0] idx,
                                                       input logic [15:0] dur);
      frame_status_type st;
      logic [5:0] prior;
      prior = seq_frame;
      st.advanced = 1'b0;
      if (cmd == CMD_WRITE) begin
         duration_tab[idx] = dur;
         duration_set[idx] = 1'b1;
         write_count++;
      end else begin
         tick_count++;
         seq_timer = seq_timer + ms;
         if (seq_timer > duration_tab[seq_frame]) begin
            seq_frame = next_loop_frame(seq_frame);
            seq_timer = '0;
         end
         st.advanced = (seq_frame != prior);
         if (st.advanced) step_count++;
      end
      st.frame = seq_frame;
      st.going_down = seq_down;
      return st;
   endfunction

   function automatic plan_row_type tick_row(input int ms, input int f = -1, input int adv = 0,
                                             input int down = 0);
      plan_row_type r;
      r = '0;
      r.kind = ROW_BEAT;
      r.cmd = CMD_TICK;
      r.ms = ms[15:0];
      r.pinned = (f >= 0);
      r.want.frame = f[5:0];
      r.want.advanced = adv[0];
      r.want.going_down = down[0];
      return r;
   endfunction

   function automatic plan_row_type write_row(input int idx, input int dur, input int f = -1,
                                              input int down = 0);
      plan_row_type r;
      r = '0;
      r.kind = ROW_BEAT;
      r.cmd = CMD_WRITE;
      r.idx = idx[5:0];
      r.dur = dur[15:0];
      r.pinned = (f >= 0);
      r.want.frame = f[5:0];
      r.want.going_down = down[0];
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input int val);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = val[6:0];
      return r;
   endfunction

   task automatic send_beat(input logic cmd, input logic [15:0] ms, input logic [5:0] idx,
                            input logic [15:0] dur, input logic pinned,
                            input frame_status_type want);
      int gap;
      frame_status_type predicted;
      gap = pick_gap(tx_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {2'b00, dur, idx, ms};
      do @(posedge clock); while (!req_tready);
      predicted = step_sequencer(cmd, ms, idx, dur);
      status_queue.push_back(pinned ? want : predicted);
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOOP_MODE:   seq_mode = val[1:0];
         CSR_FIRST_FRAME: seq_first = val[5:0];
         CSR_FRAME_COUNT: seq_count = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("animation_frame_sequencer_core_test: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_status
      frame_status_type got;
      frame_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         status_seen++;
         if (status_queue.size() == 0) begin
            $error("response beat with nothing pending: current_frame %0d", got.frame);
            fault_count++;
         end else begin
            want = status_queue.pop_front();
            if (got.frame !== want.frame) begin
               $error("current_frame: expected %0d, got %0d", want.frame, got.frame);
               fault_count++;
            end
            if (got.advanced !== want.advanced) begin
               $error("advanced: expected %0d, got %0d", want.advanced, got.advanced);
               fault_count++;
            end
            if (got.going_down !== want.going_down) begin
               $error("going_down: expected %0d, got %0d", want.going_down, got.going_down);
               fault_count++;
            end
         end
         rx_hold = (status_seen == HOLD_AT) ? LONG_HOLD : pick_gap(rx_mode);
      end
   end

   initial begin
      int i;
      int ph;
      int n;
      int r;
      logic [1:0] m;
      logic [5:0] f;
      logic [6:0] c;
      logic cmd;
      logic [15:0] ms;
      logic [15:0] dur;
      logic [5:0] idx;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_TICK;
      csr_valid <= 1'b0;
      csr_index <= CSR_LOOP_MODE;
      csr_data <= '0;

      seq_mode = MODE_FORWARD;
      seq_first = '0;
      seq_count = 7'd1;
      seq_timer = '0;
      seq_frame = '0;
      seq_down = 1'b0;
      foreach (duration_set[k]) begin
         duration_set[k] = 1'b0;
         duration_tab[k] = '0;
      end
      tx_mode = 1;
      rx_mode = 1;

      plan = '{
         write_row(0, 0, 0, 0),
         tick_row(0, 0, 0, 0),
         tick_row(65535, 0, 0, 0),
         write_row(63, 65535, 0, 0),
         write_row(1, 65535, 0, 0),
         write_row(2, 3, 0, 0),
         csr_row(CSR_FRAME_COUNT, 3),
         tick_row(1, 1, 1, 0),
         tick_row(65535, 1, 0, 0),
         tick_row(1, 1, 0, 0),
         write_row(1, 5),
         csr_row(CSR_LOOP_MODE, MODE_REVERSE),
         tick_row(6, 0, 1, 0),
         tick_row(1, 2, 1, 0),
         csr_row(CSR_LOOP_MODE, MODE_PING_PONG),
         tick_row(4, 1, 1, 1),
         tick_row(6),
         tick_row(1),
         csr_row(CSR_LOOP_MODE, MODE_PING_PONG_REV),
         tick_row(6),
         csr_row(CSR_FIRST_FRAME, 63),
         csr_row(CSR_FRAME_COUNT, 64),
         tick_row(1),
         csr_row(CSR_FRAME_COUNT, 0),
         csr_row(CSR_LOOP_MODE, MODE_FORWARD),
         tick_row(6),
         write_row(3, 0),
         tick_row(65535),
         tick_row(1)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_drain();
            write_csr(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            send_beat(plan[i].cmd, plan[i].ms, plan[i].idx, plan[i].dur, plan[i].pinned,
                      plan[i].want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin m = MODE_FORWARD;       f = 6'd0;  c = 7'd64;  end
            1: begin m = MODE_REVERSE;       f = 6'd63; c = 7'd1;   end
            2: begin m = MODE_PING_PONG;     f = 6'd10; c = 7'd8;   end
            3: begin m = MODE_PING_PONG_REV; f = 6'd60; c = 7'd127; end
            4: begin m = MODE_FORWARD;       f = 6'd5;  c = 7'd0;   end
            5: begin m = MODE_PING_PONG;     f = 6'd0;  c = 7'd1;   end
            6: begin m = MODE_REVERSE;       f = 6'd0;  c = 7'd64;  end
            7: begin m = MODE_PING_PONG_REV; f = 6'd63; c = 7'd0;   end
            default: begin
               m = 2'($urandom_range(0, 3));
               f = 6'($urandom_range(0, 63));
               r = $urandom_range(0, 9);
               c = (r < 7) ? 7'($urandom_range(1, 12)) : 7'($urandom_range(0, 127));
            end
         endcase
         wait_drain();
         write_csr(CSR_LOOP_MODE, {5'd0, m});
         write_csr(CSR_FIRST_FRAME, {1'b0, f});
         write_csr(CSR_FRAME_COUNT, c);
         tx_mode = (ph % 4 == 1) ? 0 : 1;
         rx_mode = (ph % 3 == 2) ? 0 : 1;

         for (n = 0; n < PHASE_BEATS; n++) begin
            idx = 6'($urandom_range(0, 63));
            ms = 16'($urandom_range(0, 65535));
            dur = 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 9);
            if (!duration_set[seq_frame] || r < 2) begin
               cmd = CMD_WRITE;
               if (!duration_set[seq_frame]) idx = seq_frame;
               r = $urandom_range(0, 9);
               if (r < 7) dur = 16'($urandom_range(0, 15));
               else if (r < 9) dur = 16'($urandom_range(0, 255));
            end else begin
               cmd = CMD_TICK;
               r = $urandom_range(0, 9);
               if (r < 6) ms = 16'($urandom_range(0, 12));
               else if (r < 8) ms = 16'($urandom_range(0, 300));
            end
            send_beat(cmd, ms, idx, dur, 1'b0, '0);
         end
      end

      wait_drain();
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d ticks with %0d frame steps and %0d duration writes,",
               tick_count, step_count, write_count);
      $display("over %0d loop settings in all four modes, with stalls on both sides.",
               PHASES + 1);
      if (fault_count == 0) begin
         $display("animation_frame_sequencer_core_test: done, clean");
      end else begin
         $display("animation_frame_sequencer_core_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
